// File: rtl/sorted_priority_queue_assert.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// a condition that holds on every clock edge out of reset
`define SPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// a trigger in one cycle implies a condition in the next
`define SPQ_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   localparam logic [DATA_W-1:0] EMPTY_DATA = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] ZERO_DATA  = '0;

   // what one cell shows its neighbors
   typedef struct packed {
      logic              valid;
      logic              ge;
      logic [DATA_W-1:0] data;
   } link_type;

   // the operation broadcast to every cell
   typedef struct packed {
      logic              step;
      cmd_type           cmd;
      logic [DATA_W-1:0] value;
   } op_type;

endpackage

// File: rtl/sorted_priority_queue.sv
// sorted priority queue: holds up to DEPTH signed 32-bit values in ascending
// order in a row of cells, slot 0 always holding the smallest. an enqueue
// request inserts its value ahead of the first stored value greater than or
// equal to it; every cell compares the broadcast value with its own entry and
// either keeps it, takes the new value, or takes its left neighbor's entry, so
// all cells update at the same edge. a dequeue request returns slot 0 and
// every cell takes its right neighbor's entry. each request yields exactly one
// response carrying data_out, status, occupancy and queue_empty. a dequeue on
// an empty queue answers -1 with empty status; an enqueue into a full queue is
// dropped with full status and data 0. rate: one request per cycle while
// rsp_ready stays high; the single response register frees in the cycle its
// response is taken, so a new request is taken in that same cycle, and none is
// taken while a response waits for rsp_ready; the response is registered and
// appears in the cycle after its request is taken. the critical path is one
// 32-bit signed compare in each cell plus a four-way select, with req_value
// fanned out to all DEPTH cells. occupancy is reported modulo 32.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  spq_pkg::cmd_type                  req_cmd,
   input  logic signed [spq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_data_out,
   output spq_pkg::status_type               rsp_status,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy,
   output logic                              rsp_queue_empty
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // cell row and its neighbor links
   link_type           links [DEPTH];
   link_type           prev_links [DEPTH];
   link_type           next_links [DEPTH];
   logic [DEPTH-1:0]   valid_vec;
   op_type             op;

   // fill count
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic [DATA_W-1:0]  rsp_data_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [CNT_W-1:0]   rsp_count_ff;

   logic               accept;
   logic               full;
   logic               empty;
   logic               change;
   logic [OCC_W+CNT_W-1:0] occ_wide;

   // response slot frees up as soon as the held response is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = valid_vec[DEPTH-1];
   assign empty     = !valid_vec[0];

   // cells only move on a request that actually changes the contents
   assign change   = accept && ((req_cmd == CMD_DEQUEUE) ? !empty : !full);
   assign op.step  = change;
   assign op.cmd   = req_cmd;
   assign op.value = req_value;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign prev_links[gi] = '0;
         end else begin : g_body
            assign prev_links[gi] = links[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign next_links[gi] = '0;
         end else begin : g_mid
            assign next_links[gi] = links[gi+1];
         end

         spq_cell u_cell (
            .clock (clock),
            .reset (reset),
            .op    (op),
            .prev  (prev_links[gi]),
            .next  (next_links[gi]),
            .self  (links[gi])
         );

         assign valid_vec[gi] = links[gi].valid;
      end
   endgenerate

   // next count and response contents
   always_comb begin
      count_in      = count_ff;
      rsp_data_in   = ZERO_DATA;
      rsp_status_in = STATUS_OK;
      if (req_cmd == CMD_DEQUEUE) begin
         if (empty) begin
            rsp_data_in   = EMPTY_DATA;
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_data_in = links[0].data;
            count_in    = count_ff - CNT_W'(1);
         end
      end else begin
         if (full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   // occupancy is the count taken modulo 32
   assign occ_wide = {{OCC_W{1'b0}}, rsp_count_ff};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = $signed(rsp_data_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_occupancy   = occ_wide[OCC_W-1:0];
   assign rsp_queue_empty = (rsp_count_ff == '0);

   // count tracks the occupied cells
   `SPQ_ASSERT_ALWAYS(a_count_matches_cells, clock, reset,
      $countones(valid_vec) == count_ff, "fill count differs from occupied cells")

   // occupied cells form an unbroken run from the head
   `SPQ_ASSERT_ALWAYS(a_cells_packed, clock, reset,
      ((valid_vec >> 1) & ~valid_vec) == '0, "gap in occupied cells")

   // a taken enqueue into a non-full queue grows the queue by one
   `SPQ_ASSERT_NEXT(a_enqueue_grows, clock, reset,
      accept && req_cmd == CMD_ENQUEUE && !full,
      count_ff == $past(count_ff) + CNT_W'(1), "enqueue did not grow the queue")

endmodule

// File: rtl/spq_cell.sv
module spq_cell (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::op_type   op,
   input  spq_pkg::link_type prev,
   input  spq_pkg::link_type next,
   output spq_pkg::link_type self
);
   import spq_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              ge;

   // empty slot counts as greater, so a value above every entry lands in the first free cell
   assign ge = !valid_ff || ($signed(data_ff) >= $signed(op.value));

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (op.step) begin
         if (op.cmd == CMD_DEQUEUE) begin
            valid_in = next.valid;
            data_in  = next.data;
         end else if (prev.ge) begin
            valid_in = prev.valid;
            data_in  = prev.data;
         end else if (ge) begin
            valid_in = 1'b1;
            data_in  = op.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign self.valid = valid_ff;
   assign self.ge    = ge;
   assign self.data  = data_ff;

endmodule

// File: dv/tb_sorted_priority_queue.sv
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH           = 16;
   localparam int RANDOM_REQUESTS = 500;
   localparam int STALL_LIMIT     = 3000;   // cycles with no handshake on either channel
   localparam int TAIL_CYCLES     = 8;      // margin after the last response

   // receiver stall patterns
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PERIODIC
   } ready_mode_type;

   // one expected response, field for field
   typedef struct {
      logic signed [DATA_W-1:0] data_out;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
      logic                     queue_empty;
   } queue_result_type;

   // sorted-queue predictor plus the fifo of responses still owed
   class spq_checker;
      logic signed [DATA_W-1:0] stored[$];     // ascending, slot 0 smallest
      queue_result_type         awaited[$];
      int                       errors;

      function new();
         errors = 0;
      endfunction

      // apply one accepted request to the predicted queue
      function void note_request(cmd_type cmd, logic signed [DATA_W-1:0] value);
         queue_result_type r;
         int pos;
         r.data_out = ZERO_DATA;
         r.status   = STATUS_OK;
         if (cmd == CMD_ENQUEUE) begin
            if (stored.size() >= DEPTH) begin
               // full: value dropped, queue untouched
               r.status = STATUS_FULL;
            end else begin
               // goes ahead of the first entry >= value
               pos = 0;
               while (pos < stored.size() && stored[pos] < value) pos++;
               stored.insert(pos, value);
            end
         end else if (stored.size() == 0) begin
            r.data_out = EMPTY_DATA;
            r.status   = STATUS_EMPTY;
         end else begin
            r.data_out = stored.pop_front();
         end
         r.occupancy   = OCC_W'(stored.size());
         r.queue_empty = (stored.size() == 0);
         awaited.push_back(r);
      endfunction

      function void compare_field(string label, logic signed [DATA_W-1:0] want,
                                  logic signed [DATA_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         end
      endfunction

      // match one accepted response against the oldest expectation
      function void check_response(logic signed [DATA_W-1:0] data_out, status_type status,
                                   logic [OCC_W-1:0] occupancy, logic queue_empty);
         queue_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, expected none actual data_out %0d",
                     $time, data_out);
            return;
         end
         want = awaited.pop_front();
         compare_field("data_out", want.data_out, data_out);
         compare_field("status", want.status, status);
         compare_field("occupancy", want.occupancy, occupancy);
         compare_field("queue_empty", want.queue_empty, queue_empty);
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, known values from time zero
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   cmd_type                  req_cmd   = CMD_ENQUEUE;
   logic signed [DATA_W-1:0] req_value = '0;

   // response channel
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_data_out;
   status_type               rsp_status;
   logic [OCC_W-1:0]         rsp_occupancy;
   logic                     rsp_queue_empty;

   spq_checker sb = new();

   // sender burst state, shared by directed and random parts
   int burst_left = 0;

   // receiver pattern state
   ready_mode_type ready_mode  = READY_ALWAYS;
   int             ready_span  = 0;
   int             ready_phase = 0;

   // watchdog
   int idle_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_queue_empty (rsp_queue_empty)
   );

   // monitor: values read here are the ones present before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_cmd, req_value);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_data_out, rsp_status, rsp_occupancy, rsp_queue_empty);
      end
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: a new stall pattern whenever the current span runs out
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_span <= $urandom_range(16, 96);
      end else begin
         ready_span <= ready_span - 1;
      end
      ready_phase <= (ready_phase + 1) % 3;
      case (ready_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_RARELY:   rsp_ready <= ($urandom_range(0, 3) == 0);
         default:        rsp_ready <= (ready_phase != 0);
      endcase
   end

   // mix of full-range, small clustered (equal values) and extreme values
   function automatic logic signed [DATA_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (pick <= 2) return int'($urandom_range(0, 16)) - 8;
      return $urandom;
   endfunction

   // present one request, hold until taken, then maybe end the burst
   task automatic send_request(cmd_type cmd, logic signed [DATA_W-1:0] value);
      int gap;
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap        = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new requests until every response is back; the extra edge lets
   // the monitor log a request taken at the edge this task was entered on
   task automatic wait_until_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      int fill_bias;
      int choice;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: dequeue from empty
      send_request(CMD_DEQUEUE, 32'h1234_5678);

      // directed: extremes, zero, minus one, equal values
      send_request(CMD_ENQUEUE, 32'h7FFF_FFFF);
      send_request(CMD_ENQUEUE, 32'h8000_0000);
      send_request(CMD_ENQUEUE, 0);
      send_request(CMD_ENQUEUE, -1);
      send_request(CMD_ENQUEUE, -1);
      send_request(CMD_ENQUEUE, 1);

      // directed: fill up, then an enqueue into a full queue
      repeat (DEPTH - 6) send_request(CMD_ENQUEUE, pick_value());
      send_request(CMD_ENQUEUE, 5);

      // directed: pull a few smallest values back out
      repeat (5) send_request(CMD_DEQUEUE, pick_value());

      // random: alternating fill-leaning and drain-leaning phases so both
      // the full and the empty boundary keep getting hit
      fill_bias = 50;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0)
            fill_bias = ((n / 40) % 2 == 0) ? $urandom_range(65, 90) : $urandom_range(10, 35);
         // one full pause mid-run with everything answered
         if (n == RANDOM_REQUESTS / 2) wait_until_answered();
         choice = $urandom_range(1, 100);
         send_request((choice <= fill_bias) ? CMD_ENQUEUE : CMD_DEQUEUE, pick_value());
      end

      wait_until_answered();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
